// ----- hdl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros
// Assertion helpers shared by the RTL files.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is high.
`define RRS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds during reset.
`define RRS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/rrs_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rrs_pkg
// Types and constants for the round-robin schedule-time block.
// ---------------------------------------------------------------------------
package rrs_pkg;

  localparam int TIME_W = 12;  // arrival, burst, quantum
  localparam int CLK_W  = 17;  // completion, turnaround, waiting
  localparam int PID_W  = 5;

  localparam logic [TIME_W-1:0] QUANTUM_RESET = TIME_W'(4);

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_RANK,
    ST_START,
    ST_POP,
    ST_SERVE,
    ST_ADMIT,
    ST_REQUEUE,
    ST_FIND,
    ST_EMIT,
    ST_WAIT
  } rrs_state_t;

  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
  } ring_ctrl_t;

endpackage

// ----- hdl/rrs_in_if.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rrs_in_if
// Job input channel: arrival, burst and last flag.
// ---------------------------------------------------------------------------
interface rrs_in_if;
  logic                       valid;
  logic                       ready;
  logic [rrs_pkg::TIME_W-1:0] arrival_time;
  logic [rrs_pkg::TIME_W-1:0] burst_time;
  logic                       in_last;

  modport source (output valid, output arrival_time, output burst_time,
                  output in_last, input ready);
  modport sink   (input valid, input arrival_time, input burst_time,
                  input in_last, output ready);
endinterface

// ----- hdl/rrs_out_if.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rrs_out_if
// Result channel: one transaction per job, in arrival order.
// ---------------------------------------------------------------------------
interface rrs_out_if;
  logic                       valid;
  logic                       ready;
  logic [rrs_pkg::PID_W-1:0]  process_id;
  logic [rrs_pkg::TIME_W-1:0] arrival_out;
  logic [rrs_pkg::TIME_W-1:0] burst_out;
  logic [rrs_pkg::CLK_W-1:0]  completion_time;
  logic [rrs_pkg::CLK_W-1:0]  turnaround_time;
  logic [rrs_pkg::CLK_W-1:0]  waiting_time;
  logic                       out_last;

  modport source (output valid, output process_id, output arrival_out,
                  output burst_out, output completion_time,
                  output turnaround_time, output waiting_time,
                  output out_last, input ready);
  modport sink   (input valid, input process_id, input arrival_out,
                  input burst_out, input completion_time,
                  input turnaround_time, input waiting_time,
                  input out_last, output ready);
endinterface

// ----- hdl/round_robin_schedule_times.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// round_robin_schedule_times
// Loads a job set, ranks it by arrival and replays round-robin service
// slice by slice, then streams per-job completion, turnaround and waiting.
// ---------------------------------------------------------------------------
//  channel  | dir | handshake         | payload
//  in_ch    | in  | valid/ready       | arrival_time, burst_time, in_last
//  out_ch   | out | valid/ready       | process_id .. waiting_time, out_last
//  cfg      | in  | cfg_we            | cfg_wdata = time_quantum
//
//  Jobs load back to back while in_ch.valid is high. After the last job:
//  ranking (n compares per job, one compare per cycle), a setup step, then
//  per slice pop, serve, n admission checks and requeue, plus an idle
//  search over up to n jobs when the ring runs dry, then emit and wait per
//  result. The serve step and the idle search advance the scheduling time.
//  Synchronous reset clears control state and sets the quantum to 4.
//  in_ch.ready is high only while loading; a stalled result holds in the output register.
// ---------------------------------------------------------------------------
module round_robin_schedule_times #(
  parameter int MAX_PROCS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [rrs_pkg::TIME_W-1:0] cfg_wdata,
  rrs_in_if.sink                     in_ch,
  rrs_out_if.source                  out_ch
);
  import rrs_pkg::*;

  localparam int IDX_W = $clog2(MAX_PROCS);
  localparam int CNT_W = $clog2(MAX_PROCS + 1);
  localparam logic [CNT_W-1:0] FULL_M1 = CNT_W'(MAX_PROCS - 1);

  rrs_state_t state, state_next;

  logic [TIME_W-1:0] time_quantum;
  logic [TIME_W-1:0] q;

  // load-order stores
  logic [TIME_W-1:0] ld_arr [MAX_PROCS];
  logic [TIME_W-1:0] ld_burst [MAX_PROCS];
  // arrival-ordered stores
  logic [TIME_W-1:0] job_arrival [MAX_PROCS];
  logic [TIME_W-1:0] job_burst [MAX_PROCS];
  logic [TIME_W-1:0] job_remaining [MAX_PROCS];
  logic [CLK_W-1:0]  job_completion [MAX_PROCS];
  logic [PID_W-1:0]  job_order_id [MAX_PROCS];
  logic [MAX_PROCS-1:0] job_admitted;
  logic [MAX_PROCS-1:0] job_done;

  logic [CNT_W-1:0] jobs_loaded;
  logic [CNT_W-1:0] n;
  logic [CNT_W-1:0] jobs_finished;
  logic [CLK_W-1:0] sim_clock;
  logic [IDX_W-1:0] i;
  logic [IDX_W-1:0] j;
  logic [IDX_W-1:0] rank;
  logic [IDX_W-1:0] cur;

  ring_ctrl_t       ring_ctrl;
  logic [IDX_W-1:0] ring_push_idx;
  logic [IDX_W-1:0] ring_pop_idx;
  logic             ring_empty;

  logic             in_fire;
  logic             load_last;
  logic             i_end;
  logic             j_end;
  logic             rank_less;
  logic [IDX_W-1:0] rank_final;
  logic             fits;
  logic             admit_hit;
  logic             requeue_cur;
  logic             find_hit;

  logic [CLK_W-1:0] tat;

  assign q         = (time_quantum == '0) ? TIME_W'(1) : time_quantum;
  assign in_fire   = in_ch.valid && in_ch.ready;
  assign load_last = in_ch.in_last || (jobs_loaded == FULL_M1);
  assign i_end     = (CNT_W'(i) == CNT_W'(n - CNT_W'(1)));
  assign j_end     = (CNT_W'(j) == CNT_W'(n - CNT_W'(1)));
  // stable order: earlier arrival, or same arrival and earlier load slot
  assign rank_less = (ld_arr[j] < ld_arr[i]) || ((ld_arr[j] == ld_arr[i]) && (j < i));
  assign rank_final = rank + IDX_W'(rank_less);
  assign fits      = job_remaining[cur] <= q;
  assign admit_hit = !job_admitted[i] && (CLK_W'(job_arrival[i]) <= sim_clock);
  assign requeue_cur = !job_done[cur];
  assign find_hit  = !job_done[i];

  rrs_ring #(.DEPTH(MAX_PROCS)) u_ring (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ring_ctrl),
    .push_idx (ring_push_idx),
    .pop_idx  (ring_pop_idx),
    .empty    (ring_empty)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD:    if (in_fire && load_last) state_next = ST_RANK;
      ST_RANK:    if (j_end && i_end) state_next = ST_START;
      ST_START:   state_next = ST_POP;
      ST_POP:     state_next = ST_SERVE;
      ST_SERVE:   state_next = ST_ADMIT;
      ST_ADMIT:   if (i_end) state_next = ST_REQUEUE;
      ST_REQUEUE: state_next = (ring_empty && !requeue_cur) ? ST_FIND : ST_POP;
      ST_FIND: begin
        priority if (find_hit) state_next = ST_POP;
        else if (i_end) state_next = ST_EMIT;
      end
      ST_EMIT:    state_next = ST_WAIT;
      ST_WAIT: begin
        if (out_ch.ready) state_next = i_end ? ST_LOAD : ST_EMIT;
      end
      default:    state_next = ST_LOAD;
    endcase
  end

  // handshake and ring control
  always_comb begin
    in_ch.ready     = 1'b0;
    out_ch.valid    = 1'b0;
    ring_ctrl       = '0;
    ring_push_idx   = i;
    unique case (state)
      ST_LOAD:    in_ch.ready = 1'b1;
      ST_START: begin
        ring_ctrl.clear = 1'b1;
        ring_ctrl.push  = 1'b1;
        ring_push_idx   = '0;
      end
      ST_POP:     ring_ctrl.pop = 1'b1;
      ST_ADMIT:   ring_ctrl.push = admit_hit;
      ST_REQUEUE: begin
        ring_ctrl.push = requeue_cur;
        ring_push_idx  = cur;
      end
      ST_FIND:    ring_ctrl.push = find_hit;
      ST_WAIT:    out_ch.valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_LOAD;
      time_quantum <= QUANTUM_RESET;
    end else begin
      state <= state_next;
      if (cfg_we) time_quantum <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      jobs_loaded   <= '0;
      jobs_finished <= '0;
      sim_clock     <= '0;
      job_admitted  <= '0;
      job_done      <= '0;
      n             <= '0;
      i             <= '0;
      j             <= '0;
      rank          <= '0;
      cur           <= '0;
    end else begin
      unique case (state)
        ST_LOAD: begin
          if (in_fire) begin
            ld_arr[jobs_loaded[IDX_W-1:0]]   <= in_ch.arrival_time;
            ld_burst[jobs_loaded[IDX_W-1:0]] <= in_ch.burst_time;
            jobs_loaded <= jobs_loaded + CNT_W'(1);
            n    <= jobs_loaded + CNT_W'(1);
            i    <= '0;
            j    <= '0;
            rank <= '0;
          end
        end
        ST_RANK: begin
          if (j_end) begin
            job_arrival[rank_final]   <= ld_arr[i];
            job_burst[rank_final]     <= ld_burst[i];
            job_remaining[rank_final] <= ld_burst[i];
            job_order_id[rank_final]  <= PID_W'(32'(i) + 32'd1);
            rank <= '0;
            j    <= '0;
            i    <= i + IDX_W'(1);
          end else begin
            rank <= rank_final;
            j    <= j + IDX_W'(1);
          end
        end
        ST_START: begin
          job_admitted  <= MAX_PROCS'(1);
          job_done      <= '0;
          jobs_finished <= '0;
          sim_clock     <= CLK_W'(job_arrival[0]);
        end
        ST_POP: cur <= ring_pop_idx;
        ST_SERVE: begin
          i <= '0;
          if (fits) begin
            sim_clock           <= sim_clock + CLK_W'(job_remaining[cur]);
            job_completion[cur] <= sim_clock + CLK_W'(job_remaining[cur]);
            job_remaining[cur]  <= '0;
            job_done[cur]       <= 1'b1;
            jobs_finished       <= jobs_finished + CNT_W'(1);
          end else begin
            sim_clock          <= sim_clock + CLK_W'(q);
            job_remaining[cur] <= job_remaining[cur] - q;
          end
        end
        ST_ADMIT: begin
          if (admit_hit) job_admitted[i] <= 1'b1;
          if (!i_end) i <= i + IDX_W'(1);
        end
        ST_REQUEUE: i <= '0;
        ST_FIND: begin
          if (find_hit) begin
            if (CLK_W'(job_arrival[i]) > sim_clock) begin
              sim_clock       <= CLK_W'(job_arrival[i]);
              job_admitted[i] <= 1'b1;
            end
          end else if (i_end) begin
            i <= '0;
          end else begin
            i <= i + IDX_W'(1);
          end
        end
        ST_EMIT: ;
        ST_WAIT: begin
          if (out_ch.ready) begin
            i <= i + IDX_W'(1);
            if (i_end) begin
              jobs_loaded   <= '0;
              jobs_finished <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // result register
  assign tat = out_ch.completion_time - CLK_W'(out_ch.arrival_out);

  always_ff @(posedge clk) begin
    if (state == ST_EMIT) begin
      out_ch.process_id      <= job_order_id[i];
      out_ch.arrival_out     <= job_arrival[i];
      out_ch.burst_out       <= job_burst[i];
      out_ch.completion_time <= job_completion[i];
      out_ch.out_last        <= i_end;
    end
  end

  assign out_ch.turnaround_time = tat;
  assign out_ch.waiting_time    = tat - CLK_W'(out_ch.burst_out);

  `include "assert_macros.svh"

  `RRS_ASSERT(a_no_overlap, clk, rst, !(in_ch.ready && out_ch.valid), "load and emit overlap")
  `RRS_ASSERT(a_last_stops_load, clk, rst, (in_fire && in_ch.in_last) |=> !in_ch.ready, "load continued after last")
  `RRS_ASSERT(a_finished_bound, clk, rst, jobs_finished <= n, "more jobs finished than loaded")

endmodule

// ----- hdl/rrs_ring.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rrs_ring
// FIFO ready queue of job slots. Clear may coincide with a push.
// ---------------------------------------------------------------------------
module rrs_ring #(
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  rrs_pkg::ring_ctrl_t      ctrl,
  input  logic [$clog2(DEPTH)-1:0] push_idx,
  output logic [$clog2(DEPTH)-1:0] pop_idx,
  output logic                     empty
);
  import rrs_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(DEPTH - 1);

  logic [IDX_W-1:0] slots [DEPTH];
  logic [IDX_W-1:0] head;
  logic [IDX_W-1:0] tail;
  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] wr_pos;

  assign wr_pos  = ctrl.clear ? '0 : tail;
  assign pop_idx = slots[head];
  assign empty   = (count == '0);

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      slots[wr_pos] <= push_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else if (ctrl.clear) begin
      head  <= '0;
      tail  <= ctrl.push ? IDX_W'(1) : '0;
      count <= ctrl.push ? CNT_W'(1) : '0;
    end else begin
      if (ctrl.push) begin
        tail <= (tail == LAST_POS) ? '0 : tail + IDX_W'(1);
      end
      if (ctrl.pop) begin
        head <= (head == LAST_POS) ? '0 : head + IDX_W'(1);
      end
      if (ctrl.push && !ctrl.pop) begin
        count <= count + CNT_W'(1);
      end else if (ctrl.pop && !ctrl.push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  `include "assert_macros.svh"

  `RRS_ASSERT(a_no_pop_empty, clk, rst, (ctrl.pop && !ctrl.clear) |-> !empty, "pop from empty ring")
  `RRS_ASSERT(a_no_push_full, clk, rst, (ctrl.push && !ctrl.pop && !ctrl.clear) |-> (count != CNT_W'(DEPTH)), "push into full ring")
  `RRS_ASSERT(a_count_bound, clk, rst, count <= CNT_W'(DEPTH), "ring count overflow")

endmodule

// ----- bench/rrs_sched_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rrs_sched_checker
// Watches the job and result channels and the quantum register, replays
// each loaded job set through a round-robin schedule and compares every
// result transaction against the predicted per-job times.
// ---------------------------------------------------------------------------
module rrs_sched_checker #(
  parameter int MAX_PROCS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [rrs_pkg::TIME_W-1:0] cfg_wdata,
  rrs_in_if                          in_ch,
  rrs_out_if                         out_ch,
  output int                         results_pending,
  output int                         results_checked,
  output int                         mismatches
);
  import rrs_pkg::*;

  typedef struct packed {
    logic [PID_W-1:0]  pid;
    logic [TIME_W-1:0] arrival;
    logic [TIME_W-1:0] burst;
    logic [CLK_W-1:0]  completion;
    logic [CLK_W-1:0]  turnaround;
    logic [CLK_W-1:0]  waiting;
    logic              last;
  } job_times_t;

  job_times_t        job_times_q[$];
  logic [TIME_W-1:0] quantum;
  logic [TIME_W-1:0] load_arrival[MAX_PROCS];
  logic [TIME_W-1:0] load_burst[MAX_PROCS];
  int                load_count;

  // Stable sort by arrival, then slice-by-slice round-robin service.
  function automatic void schedule_set(int n, int q);
    int arr[MAX_PROCS], bst[MAX_PROCS], rem[MAX_PROCS], id[MAX_PROCS];
    int comp[MAX_PROCS];
    bit admitted[MAX_PROCS], done[MAX_PROCS];
    int ring[$];
    int now, finished, cur, t;
    job_times_t r;
    for (int i = 0; i < n; i++) begin
      arr[i] = load_arrival[i];
      bst[i] = load_burst[i];
      id[i] = i + 1;
      admitted[i] = 0;
      done[i] = 0;
    end
    for (int i = 0; i < n; i++)
      for (int j = 0; j + 1 < n - i; j++)
        if (arr[j] > arr[j+1]) begin
          t = arr[j]; arr[j] = arr[j+1]; arr[j+1] = t;
          t = bst[j]; bst[j] = bst[j+1]; bst[j+1] = t;
          t = id[j];  id[j] = id[j+1];   id[j+1] = t;
        end
    for (int i = 0; i < n; i++) rem[i] = bst[i];
    finished = 0;
    now = arr[0];
    ring.push_back(0);
    admitted[0] = 1;
    while (finished < n && ring.size() != 0) begin
      cur = ring.pop_front();
      if (rem[cur] <= q) begin
        now += rem[cur];
        rem[cur] = 0;
        comp[cur] = now;
        done[cur] = 1;
        finished++;
      end else begin
        rem[cur] -= q;
        now += q;
      end
      // new arrivals go ahead of the preempted job
      for (int i = 0; i < n; i++)
        if (!admitted[i] && arr[i] <= now) begin
          admitted[i] = 1;
          ring.push_back(i);
        end
      if (!done[cur]) ring.push_back(cur);
      if (ring.size() == 0) begin
        for (int i = 0; i < n; i++)
          if (!done[i]) begin
            if (arr[i] > now) begin
              now = arr[i];
              admitted[i] = 1;
            end
            ring.push_back(i);
            break;
          end
      end
    end
    for (int i = 0; i < n; i++) begin
      r.pid        = PID_W'(id[i]);
      r.arrival    = TIME_W'(arr[i]);
      r.burst      = TIME_W'(bst[i]);
      r.completion = CLK_W'(comp[i]);
      r.turnaround = CLK_W'(comp[i] - arr[i]);
      r.waiting    = CLK_W'(comp[i] - arr[i] - bst[i]);
      r.last       = (i == n - 1);
      job_times_q.push_back(r);
    end
  endfunction

  always @(posedge clk) begin
    job_times_t got, want;
    if (rst) begin
      quantum <= QUANTUM_RESET;
      load_count = 0;
      job_times_q.delete();
      results_pending <= 0;
      results_checked <= 0;
      mismatches <= 0;
    end else begin
      if (cfg_we) quantum <= cfg_wdata;
      if (in_ch.valid && in_ch.ready) begin
        load_arrival[load_count] = in_ch.arrival_time;
        load_burst[load_count] = in_ch.burst_time;
        load_count++;
        // a full store closes the set even without the last flag
        if (in_ch.in_last || load_count == MAX_PROCS) begin
          schedule_set(load_count, (quantum == 0) ? 1 : int'(quantum));
          load_count = 0;
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.process_id, out_ch.arrival_out, out_ch.burst_out,
                out_ch.completion_time, out_ch.turnaround_time,
                out_ch.waiting_time, out_ch.out_last};
        if (job_times_q.size() == 0) begin
          if (mismatches < 10)
            $display("%0t unexpected result pid=%0d", $time, got.pid);
          mismatches <= mismatches + 1;
        end else begin
          want = job_times_q.pop_front();
          if (got !== want) begin
            if (mismatches < 10) begin
              $display("%0t mismatch exp: pid=%0d arr=%0d bst=%0d cmp=%0d tat=%0d wt=%0d last=%0b",
                       $time, want.pid, want.arrival, want.burst, want.completion,
                       want.turnaround, want.waiting, want.last);
              $display("%0t          got: pid=%0d arr=%0d bst=%0d cmp=%0d tat=%0d wt=%0d last=%0b",
                       $time, got.pid, got.arrival, got.burst, got.completion,
                       got.turnaround, got.waiting, got.last);
            end
            mismatches <= mismatches + 1;
          end
        end
        results_checked <= results_checked + 1;
      end
      results_pending <= job_times_q.size();
    end
  end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Round-robin schedule-time block: directed job sets (extremes, equal
// arrivals, idle gaps, zero bursts, full store) then random sets under
// several quantum settings, with random gaps and result back-pressure.
// ---------------------------------------------------------------------------
module tb_top;
  import rrs_pkg::*;

  localparam int MAX_PROCS   = 16;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int RANDOM_JOBS = 180;

  logic              clk = 0;
  logic              rst = 1;
  logic              cfg_we = 0;
  logic [TIME_W-1:0] cfg_wdata = '0;
  int                cycles = 0;
  int                results_pending, results_checked, mismatches;
  int                jobs_sent = 0;
  int                sets_sent = 0;
  int                sink_stall = 0;
  bit                no_idle = 0;
  logic [TIME_W-1:0] cur_quantum = QUANTUM_RESET;

  rrs_in_if  in_ch();
  rrs_out_if out_ch();

  initial begin
    in_ch.valid = 0;
    in_ch.arrival_time = '0;
    in_ch.burst_time = '0;
    in_ch.in_last = 0;
    out_ch.ready = 0;
  end

  always #2 clk = ~clk;

  round_robin_schedule_times #(.MAX_PROCS(MAX_PROCS)) u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  rrs_sched_checker #(.MAX_PROCS(MAX_PROCS)) u_checker (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_ch(in_ch), .out_ch(out_ch),
    .results_pending(results_pending), .results_checked(results_checked),
    .mismatches(mismatches)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb: failure");
      $finish;
    end
  end

  // result back-pressure: a fresh stall length after every transaction
  always @(posedge clk) begin
    int next_stall;
    if (rst) begin
      out_ch.ready <= 0;
      sink_stall <= 0;
    end else begin
      next_stall = sink_stall;
      if (out_ch.valid && out_ch.ready)
        next_stall = no_idle ? 0 : $urandom_range(0, 10);
      else if (next_stall > 0)
        next_stall--;
      sink_stall <= next_stall;
      out_ch.ready <= (next_stall == 0);
    end
  end

  task automatic send_job(input int arrival, input int burst, input bit last);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_ch.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.arrival_time <= TIME_W'(arrival);
    in_ch.burst_time <= TIME_W'(burst);
    in_ch.in_last <= last;
    @(negedge clk);
    while (!in_ch.ready) @(negedge clk);
    @(posedge clk);
    jobs_sent++;
    if (last) sets_sent++;
  endtask

  task automatic drain_results();
    in_ch.valid <= 0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_quantum(input int value);
    cfg_we <= 1;
    cfg_wdata <= TIME_W'(value);
    @(posedge clk);
    cfg_we <= 0;
    cur_quantum = TIME_W'(value);
  endtask

  initial begin
    int n, q, max_burst, max_arrival, random_jobs;
    bit last;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // single zero job, reset quantum
    send_job(0, 0, 1);
    drain_results();

    write_quantum(4095);
    send_job(4095, 4095, 1);
    drain_results();

    // zero quantum acts as one; equal arrivals keep load order; idle gap
    write_quantum(0);
    send_job(5, 3, 0);
    send_job(2, 0, 0);
    send_job(5, 2, 0);
    send_job(40, 1, 0);
    send_job(2, 4, 1);
    drain_results();

    // store full without a last flag, quantum one
    write_quantum(1);
    for (int i = 0; i < MAX_PROCS; i++)
      send_job($urandom_range(0, 31), $urandom_range(0, 6), 0);
    drain_results();

    random_jobs = 0;
    while (random_jobs < RANDOM_JOBS) begin
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 4))
          0: q = 0;
          1: q = 1;
          2: q = 4095;
          3: q = $urandom_range(2, 16);
          default: q = $urandom_range(0, 4095);
        endcase
        write_quantum(q);
      end
      q = (cur_quantum == 0) ? 1 : cur_quantum;
      // keep slice count bounded: long bursts only under a long quantum
      max_burst = (q >= 512) ? 4095 : q * 8;
      max_arrival = ($urandom_range(0, 3) == 0) ? 4095 : 63;
      no_idle = ($urandom_range(0, 4) == 0);
      n = ($urandom_range(0, 5) == 0) ? MAX_PROCS : $urandom_range(1, MAX_PROCS);
      for (int i = 0; i < n; i++) begin
        last = (i == n - 1) && (n < MAX_PROCS || $urandom_range(0, 1));
        send_job($urandom_range(0, max_arrival), $urandom_range(0, max_burst), last);
      end
      random_jobs += n;
      drain_results();
    end

    $display("ran %0d jobs in %0d flagged sets plus full-store sets", jobs_sent, sets_sent);
    $display("checked %0d per-job results over quanta 0, 1, 4095 and random", results_checked);
    if (mismatches == 0 && results_pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- round_robin_schedule_times.f -----
+incdir+hdl
hdl/rrs_pkg.sv
hdl/rrs_in_if.sv
hdl/rrs_out_if.sv
hdl/rrs_ring.sv
hdl/round_robin_schedule_times.sv
bench/rrs_sched_checker.sv
bench/tb_top.sv
